[sv/assert_macros.svh]
// Assertion macros shared by the RTL of the tap gesture classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/mtgc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers for the tap gesture classifier.
package mtgc_pkg;

    localparam int NUM_BUTTONS = 5;
    localparam int BTN_W = 3;
    localparam int TIME_W = 34;
    localparam int WIDE_W = 36;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CLICK_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_LIMIT = 2'd1;

    localparam logic MODE_EVENT = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    localparam logic [CFG_DATA_W-1:0] CLICK_WINDOW_RESET = 16'd600;
    localparam logic [CFG_DATA_W-1:0] LONG_LIMIT_RESET = 16'd5000;

    localparam logic signed [TIME_W-1:0] RESET_TIME_MS = -34'sd3600000;

    typedef enum logic [2:0] {
        CODE_NONE   = 3'd0,
        CODE_SINGLE = 3'd1,
        CODE_DOUBLE = 3'd2,
        CODE_TRIPLE = 3'd3,
        CODE_LONG   = 3'd4
    } code_t;

    typedef struct packed {
        logic signed [TIME_W-1:0] p0;
        logic signed [TIME_W-1:0] p1;
        logic signed [TIME_W-1:0] p2;
        logic signed [TIME_W-1:0] r0;
    } hist_entry_t;

    typedef hist_entry_t [NUM_BUTTONS-1:0] hist_all_t;

    typedef struct packed {
        logic             en;
        logic [BTN_W-1:0] addr;
        hist_entry_t      data;
    } store_wr_t;

    typedef struct packed {
        code_t code;
        logic  set_reported;
    } eval_t;

    localparam hist_entry_t RESET_ENTRY = '{
        p0: RESET_TIME_MS, p1: RESET_TIME_MS, p2: RESET_TIME_MS, r0: RESET_TIME_MS};

    function automatic logic signed [WIDE_W-1:0] ext_wide(input logic signed [TIME_W-1:0] v);
        return {{2{v[TIME_W-1]}}, v};
    endfunction

    function automatic logic signed [WIDE_W-1:0] dbl_wide(input logic signed [TIME_W-1:0] v);
        return {v[TIME_W-1], v, 1'b0};
    endfunction

endpackage

[sv/mtgc_classify.sv]
`timescale 1ns / 1ps
// Gesture decision for one button from its press history and last release.
module mtgc_classify
(
    input  mtgc_pkg::hist_entry_t          hist,
    input  logic                           reported,
    input  logic [31:0]                    time_ms,
    input  logic [mtgc_pkg::CFG_DATA_W-1:0] click_window,
    input  logic [mtgc_pkg::CFG_DATA_W-1:0] long_limit,
    output mtgc_pkg::eval_t                result
);

    logic signed [mtgc_pkg::WIDE_W-1:0] p0;
    logic signed [mtgc_pkg::WIDE_W-1:0] r0;
    logic signed [mtgc_pkg::WIDE_W-1:0] p0x2;
    logic signed [mtgc_pkg::WIDE_W-1:0] p1x2;
    logic signed [mtgc_pkg::WIDE_W-1:0] p2x2;
    logic signed [mtgc_pkg::WIDE_W-1:0] win;
    logic signed [mtgc_pkg::WIDE_W-1:0] lim;
    logic signed [mtgc_pkg::WIDE_W-1:0] now;
    logic late;
    logic is_triple;
    logic is_double;
    logic is_single;
    logic is_long;

    assign p0   = mtgc_pkg::ext_wide(hist.p0);
    assign r0   = mtgc_pkg::ext_wide(hist.r0);
    assign p0x2 = mtgc_pkg::dbl_wide(hist.p0);
    assign p1x2 = mtgc_pkg::dbl_wide(hist.p1);
    assign p2x2 = mtgc_pkg::dbl_wide(hist.p2);
    assign win  = $signed({20'd0, click_window});
    assign lim  = $signed({20'd0, long_limit});
    assign now  = $signed({4'd0, time_ms});

    assign late      = now > (p0 + win);
    assign is_double = (p1x2 + win) > p0x2;
    assign is_triple = is_double && ((p2x2 + win) > p1x2);
    assign is_single = (p0 < r0) && ((r0 - p0) < win);
    assign is_long   = (p0 > r0) && ((p0 + lim) > now);

    always_comb
    begin
        result.code = mtgc_pkg::CODE_NONE;
        result.set_reported = 1'b0;
        priority if (!late || reported)
        begin
            result.code = mtgc_pkg::CODE_NONE;
        end
        else if (is_triple)
        begin
            result.code = mtgc_pkg::CODE_TRIPLE;
            result.set_reported = 1'b1;
        end
        else if (is_double)
        begin
            result.code = mtgc_pkg::CODE_DOUBLE;
            result.set_reported = 1'b1;
        end
        else if (is_single)
        begin
            result.code = mtgc_pkg::CODE_SINGLE;
            result.set_reported = 1'b1;
        end
        else if (is_long)
        begin
            result.code = mtgc_pkg::CODE_LONG;
        end
        else
        begin
            result.code = mtgc_pkg::CODE_NONE;
            result.set_reported = 1'b1;
        end
    end

endmodule

[sv/mtgc_store.sv]
`timescale 1ns / 1ps
// Per-button timestamp memory with registered read and write forwarding.
module mtgc_store
(
    input  logic                clk,
    input  logic                rst_n,
    input  mtgc_pkg::store_wr_t wr,
    output mtgc_pkg::hist_all_t rd
);

    mtgc_pkg::hist_entry_t mem [mtgc_pkg::NUM_BUTTONS];
    logic [mtgc_pkg::NUM_BUTTONS-1:0] valid_reg;
    logic [mtgc_pkg::NUM_BUTTONS-1:0] valid_next;
    mtgc_pkg::hist_all_t rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        for (int b = 0; b < mtgc_pkg::NUM_BUTTONS; b++)
        begin
            if (wr.en && (wr.addr == b[mtgc_pkg::BTN_W-1:0]))
            begin
                valid_next[b] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_reg <= {mtgc_pkg::NUM_BUTTONS{mtgc_pkg::RESET_ENTRY}};
        end
        else
        begin
            valid_reg <= valid_next;
            for (int b = 0; b < mtgc_pkg::NUM_BUTTONS; b++)
            begin
                if (wr.en && (wr.addr == b[mtgc_pkg::BTN_W-1:0]))
                begin
                    rd_reg[b] <= wr.data;
                end
                else if (valid_reg[b])
                begin
                    rd_reg[b] <= mem[b];
                end
                else
                begin
                    rd_reg[b] <= mtgc_pkg::RESET_ENTRY;
                end
            end
        end
    end

    assign rd = rd_reg;

endmodule

[sv/multi_tap_gesture_classifier_unit.sv]
`timescale 1ns / 1ps
// Top level of the five-button tap gesture classifier.
// The block takes one request per cycle unless the output is blocked. Press and
// release times of the five buttons live in a small memory whose rows are read every
// cycle into a read register, with a write in the same cycle forwarded into it, so a
// request always sees the state left by the one before. A request is accepted into a
// stage register and is classified or applied to the memory from there; a nonzero
// evaluate result goes on into the output register. Event requests and evaluate
// requests with all codes zero give no result. Configuration writes are always ready.
`include "assert_macros.svh"

module multi_tap_gesture_classifier_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                mode,
    input  logic [mtgc_pkg::BTN_W-1:0]          button,
    input  logic                                pressed,
    input  logic [31:0]                         time_ms,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [2:0]                          head_front_code,
    output logic [2:0]                          head_middle_code,
    output logic [2:0]                          head_rear_code,
    output logic [2:0]                          left_bumper_code,
    output logic [2:0]                          right_bumper_code,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mtgc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mtgc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int NB = mtgc_pkg::NUM_BUTTONS;

    logic [mtgc_pkg::CFG_DATA_W-1:0] click_window_reg;
    logic [mtgc_pkg::CFG_DATA_W-1:0] long_limit_reg;

    logic                        s1_valid_reg;
    logic                        s1_mode_reg;
    logic [mtgc_pkg::BTN_W-1:0]  s1_button_reg;
    logic                        s1_pressed_reg;
    logic [31:0]                 s1_time_reg;
    logic                        s1_adv;

    logic [NB-1:0]               reported_reg;
    logic [NB-1:0]               reported_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    mtgc_pkg::code_t             code_reg [NB];

    mtgc_pkg::store_wr_t         wr;
    mtgc_pkg::hist_all_t         rd_all;
    mtgc_pkg::hist_entry_t       cur;
    mtgc_pkg::eval_t             res [NB];
    logic                        ev_ok;
    logic                        any_code;
    logic signed [mtgc_pkg::TIME_W-1:0] now_ext;

    logic                        out_code_any;
    logic                        ev_adv;
    logic                        s1_stall;
    logic                        out_blocked;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            click_window_reg <= mtgc_pkg::CLICK_WINDOW_RESET;
            long_limit_reg <= mtgc_pkg::LONG_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mtgc_pkg::REG_CLICK_WINDOW: click_window_reg <= cfg_data;
                mtgc_pkg::REG_LONG_LIMIT:   long_limit_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign s1_adv = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_mode_reg <= mode;
            s1_button_reg <= button;
            s1_pressed_reg <= pressed;
            s1_time_reg <= time_ms;
        end
    end

    mtgc_store u_store
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .rd    (rd_all)
    );

    assign ev_ok = (s1_mode_reg == mtgc_pkg::MODE_EVENT) && (s1_button_reg < 3'(NB));
    assign now_ext = $signed({2'b00, s1_time_reg});

    always_comb
    begin
        cur = mtgc_pkg::RESET_ENTRY;
        for (int b = 0; b < NB; b++)
        begin
            if (s1_button_reg == b[mtgc_pkg::BTN_W-1:0])
            begin
                cur = rd_all[b];
            end
        end
        wr.en = s1_adv && ev_ok;
        wr.addr = s1_button_reg;
        if (s1_pressed_reg)
        begin
            wr.data = '{p0: now_ext, p1: cur.p0, p2: cur.p1, r0: cur.r0};
        end
        else
        begin
            wr.data = '{p0: cur.p0, p1: cur.p1, p2: cur.p2, r0: now_ext};
        end
    end

    for (genvar g = 0; g < NB; g++)
    begin : g_btn
        mtgc_classify u_classify
        (
            .hist         (rd_all[g]),
            .reported     (reported_reg[g]),
            .time_ms      (s1_time_reg),
            .click_window (click_window_reg),
            .long_limit   (long_limit_reg),
            .result       (res[g])
        );
    end

    always_comb
    begin
        any_code = 1'b0;
        reported_next = reported_reg;
        for (int b = 0; b < NB; b++)
        begin
            if (res[b].code != mtgc_pkg::CODE_NONE)
            begin
                any_code = 1'b1;
            end
            if (wr.en && s1_pressed_reg && (s1_button_reg == b[mtgc_pkg::BTN_W-1:0]))
            begin
                reported_next[b] = 1'b0;
            end
            else if (s1_adv && (s1_mode_reg == mtgc_pkg::MODE_EVAL) && res[b].set_reported)
            begin
                reported_next[b] = 1'b1;
            end
        end
        if (s1_adv && (s1_mode_reg == mtgc_pkg::MODE_EVAL))
        begin
            out_valid_next = any_code;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reported_reg <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            reported_reg <= reported_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && (s1_mode_reg == mtgc_pkg::MODE_EVAL) && any_code)
        begin
            for (int b = 0; b < NB; b++)
            begin
                code_reg[b] <= res[b].code;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign head_front_code = code_reg[0];
    assign head_middle_code = code_reg[1];
    assign head_rear_code = code_reg[2];
    assign left_bumper_code = code_reg[3];
    assign right_bumper_code = code_reg[4];

    assign out_code_any = (head_front_code != mtgc_pkg::CODE_NONE)
                       || (head_middle_code != mtgc_pkg::CODE_NONE)
                       || (head_rear_code != mtgc_pkg::CODE_NONE)
                       || (left_bumper_code != mtgc_pkg::CODE_NONE)
                       || (right_bumper_code != mtgc_pkg::CODE_NONE);
    assign ev_adv = s1_adv && (s1_mode_reg == mtgc_pkg::MODE_EVENT);
    assign s1_stall = s1_valid_reg && !in_ready;
    assign out_blocked = out_valid && !out_ready;

    `ASSERT_SAME(a_result_nonzero, out_valid, out_code_any, "result with all codes zero")
    `ASSERT_NEXT(a_event_no_result, ev_adv, !out_valid, "event request produced a result")
    `ASSERT_SAME(a_stall_cause, s1_stall, out_blocked, "input stalled with output free")

endmodule
